// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
// Depends on nothing; every other file of the block imports it.
package spq_pkg;

  localparam int unsigned SUM_W       = 32;
  localparam int unsigned INTEREST_W  = 16;
  localparam int unsigned LATE_FEES_W = 32;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned STATUS_W    = 2;

  localparam int unsigned DEPTH_DEF   = 16;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [INTEREST_W-1:0]  interest;
    logic [LATE_FEES_W-1:0] late_fees;
    logic [TAG_W-1:0]       tag;
  } entry_t;

  // Control that the top level broadcasts to one cell.
  typedef struct packed {
    logic insert;    // an insert is taken into the row in this cycle
    logic occupied;  // the cell holds a live entry
  } cell_ctl_t;

endpackage

// ===== hw/rtl/spq_req_if.sv =====
// Request channel of the sorted priority queue: valid, ready and payload.
// Depends on spq_pkg for the field widths.
interface spq_req_if;
  import spq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SUM_W-1:0]       new_sum;
  logic [INTEREST_W-1:0]  new_interest;
  logic [LATE_FEES_W-1:0] new_late_fees;
  logic [TAG_W-1:0]       new_tag;

  modport source (
    output valid, req_type, new_sum, new_interest, new_late_fees, new_tag,
    input  ready
  );
  modport sink (
    input  valid, req_type, new_sum, new_interest, new_late_fees, new_tag,
    output ready
  );
  modport monitor (
    input valid, ready, req_type, new_sum, new_interest, new_late_fees, new_tag
  );
endinterface

// ===== hw/rtl/spq_rsp_if.sv =====
// Response channel of the sorted priority queue: valid, ready and payload.
// Depends on spq_pkg for the field widths; CNT_W follows from the depth.
interface spq_rsp_if #(
  parameter int unsigned CNT_W = 5
);
  import spq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SUM_W-1:0]       head_sum;
  logic [INTEREST_W-1:0]  head_interest;
  logic [LATE_FEES_W-1:0] head_late_fees;
  logic [TAG_W-1:0]       head_tag;
  logic [CNT_W-1:0]       entry_total;
  logic [STATUS_W-1:0]    status;

  modport source (
    output valid, head_sum, head_interest, head_late_fees, head_tag,
           entry_total, status,
    input  ready
  );
  modport sink (
    input  valid, head_sum, head_interest, head_late_fees, head_tag,
           entry_total, status,
    output ready
  );
  modport monitor (
    input valid, ready, head_sum, head_interest, head_late_fees, head_tag,
          entry_total, status
  );
endinterface

// ===== hw/rtl/spq_cell.sv =====
// One cell of the sorted row: holds a single entry, compares it with the
// broadcast new entry and takes the new entry or its neighbour's on insert.
// Depends on spq_pkg.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctl_t  ctl_i,
  input  spq_pkg::entry_t     new_ent_i,
  input  spq_pkg::entry_t     prev_ent_i,
  input  logic                prev_above_i,
  output spq_pkg::entry_t     ent_o,
  output spq_pkg::entry_t     ent_nxt_o,
  output logic                above_o
);
  import spq_pkg::*;

  entry_t ent_q, ent_d;
  logic   greater;

  // Strict lexicographic order on sum, interest, late fees; tag is payload.
  always_comb begin
    if (ent_q.sum != new_ent_i.sum) begin
      greater = ent_q.sum > new_ent_i.sum;
    end else if (ent_q.interest != new_ent_i.interest) begin
      greater = ent_q.interest > new_ent_i.interest;
    end else begin
      greater = ent_q.late_fees > new_ent_i.late_fees;
    end
  end

  assign above_o = ctl_i.occupied && greater;

  always_comb begin
    priority if (!ctl_i.insert || above_o) begin
      ent_d = ent_q;
    end else if (prev_above_i) begin
      ent_d = new_ent_i;
    end else begin
      ent_d = prev_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o     = ent_q;
  assign ent_nxt_o = ent_d;

endmodule

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue of up to DEPTH entries, kept in descending order of
// sum, then interest, then late fees, in a row of DEPTH cells. The request
// is broadcast to every cell in the cycle it is accepted; each cell compares
// the new entry with its own and, on an insert, keeps its entry, takes the
// new one or takes its upper neighbour's, so the row shifts down by one
// behind the insertion point, all cells at once. A new entry goes in ahead of
// all entries of equal rank. A remove drops the last entry by decrementing
// the count; the cell contents stay but are no longer live. Every request
// yields one response transaction carrying the head entry (all zero when the
// queue is empty), the count after the request and a status: an insert to a
// full queue is dropped and a remove from an empty queue is ignored, each
// flagged. The block takes one request transaction per cycle unless the
// response is stalled; the response is registered and valid in the cycle
// after acceptance. A request is accepted whenever the response register
// is empty or is being emptied in the same cycle.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             rsp_valid_q;
  logic             accept;
  logic             is_insert;
  logic             do_insert;
  status_e          status_d;
  entry_t           new_ent;
  entry_t           head_d;

  entry_t           ent     [DEPTH];
  entry_t           ent_nxt [DEPTH];
  logic             above   [DEPTH];
  cell_ctl_t        ctl     [DEPTH];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_insert   = req_e'(req_i.req_type) == REQ_INSERT;

  assign new_ent.sum       = req_i.new_sum;
  assign new_ent.interest  = req_i.new_interest;
  assign new_ent.late_fees = req_i.new_late_fees;
  assign new_ent.tag       = req_i.new_tag;

  // An insert to a full queue and a remove from an empty one leave the row
  // untouched and only set the status. A remove only moves the count; the
  // row needs no action for it.
  always_comb begin
    do_insert = 1'b0;
    status_d  = ST_DONE;
    count_d   = count_q;
    if (accept) begin
      if (is_insert) begin
        if (count_q == CNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + CNT_W'(1);
        end
      end else begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
    end
  end

  // The row of cells. Cell zero has no upper neighbour: the new entry lands
  // there unless the head ranks strictly above it.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign ctl[g].insert   = do_insert;
    assign ctl[g].occupied = count_q > CNT_W'(g);

    if (g == 0) begin : g_first
      spq_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (ctl[g]),
        .new_ent_i    (new_ent),
        .prev_ent_i   (new_ent),
        .prev_above_i (1'b1),
        .ent_o        (ent[g]),
        .ent_nxt_o    (ent_nxt[g]),
        .above_o      (above[g])
      );
    end else begin : g_rest
      spq_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (ctl[g]),
        .new_ent_i    (new_ent),
        .prev_ent_i   (ent[g-1]),
        .prev_above_i (above[g-1]),
        .ent_o        (ent[g]),
        .ent_nxt_o    (ent_nxt[g]),
        .above_o      (above[g])
      );
    end
  end

  // The head reported is the value cell zero takes at this edge, zeroed when
  // the queue is empty after the request.
  assign head_d = (count_d == '0) ? '0 : ent_nxt[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_o.head_sum       <= head_d.sum;
      rsp_o.head_interest  <= head_d.interest;
      rsp_o.head_late_fees <= head_d.late_fees;
      rsp_o.head_tag       <= head_d.tag;
      rsp_o.entry_total    <= count_d;
      rsp_o.status         <= status_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on spq_pkg and on the two channel interfaces.
module spq_checker #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_i
);
  import spq_pkg::*;

  // A stalled response transaction holds its count, status, head sum and head tag.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_i.valid && !rsp_i.ready |=>
      rsp_i.valid && $stable(rsp_i.entry_total) && $stable(rsp_i.status)
      && $stable(rsp_i.head_sum) && $stable(rsp_i.head_tag))
    else $error("response changed while stalled");

  // Every accepted request yields a response in the following cycle.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> rsp_i.valid)
    else $error("accepted request produced no response");

  // A dropped insert is only reported when the queue is full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_i.valid && rsp_i.status == ST_FULL |->
      rsp_i.entry_total == ($bits(rsp_i.entry_total))'(DEPTH))
    else $error("full status with queue not full");

  // An empty queue reports an all-zero head.
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_i.valid && rsp_i.entry_total == '0 |->
      rsp_i.head_sum == '0 && rsp_i.head_interest == '0
      && rsp_i.head_late_fees == '0 && rsp_i.head_tag == '0)
    else $error("head not zero on empty queue");

endmodule

bind sorted_priority_queue_core spq_checker #(
  .DEPTH (DEPTH)
) u_spq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_i  (rsp_o)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the sorted priority queue core (sorted_priority_queue_core).
// Depends on spq_pkg and on the request and response interfaces of the block.
module testbench;
  import spq_pkg::*;

  localparam int unsigned DEPTH     = DEPTH_DEF;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_MAX = 20000;

  // One response transaction as the queue should report it.
  typedef struct packed {
    entry_t          head;
    logic [CNT_W-1:0] total;
    status_e         status;
  } queue_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_req_if               req_if ();
  spq_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

  sorted_priority_queue_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the queue contents, in descending order of rank.
  entry_t       held[DEPTH];
  int unsigned  held_count;
  queue_reply_t expected_replies[$];

  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_pending;

  int unsigned failures;
  int unsigned inserts_sent;
  int unsigned removes_sent;
  int unsigned full_drops;
  int unsigned empty_removes;
  int unsigned peak_count;
  int unsigned replies_seen;

  // True when entry a ranks strictly above entry b; the tag plays no part.
  function automatic bit outranks(entry_t a, entry_t b);
    if (a.sum != b.sum) return a.sum > b.sum;
    if (a.interest != b.interest) return a.interest > b.interest;
    return a.late_fees > b.late_fees;
  endfunction

  // Applies one accepted request to the shadow queue and returns the reply it should cause.
  function automatic queue_reply_t apply_request(req_e kind, entry_t item);
    queue_reply_t reply;
    int unsigned  pos;
    reply.status = ST_DONE;
    if (kind == REQ_INSERT) begin
      if (held_count >= DEPTH) begin
        reply.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && outranks(held[pos], item)) pos++;
        for (int unsigned k = held_count; k > pos; k--) held[k] = held[k-1];
        held[pos] = item;
        held_count++;
      end
    end else begin
      if (held_count == 0) reply.status = ST_EMPTY;
      else held_count--;
    end
    reply.head  = (held_count > 0) ? held[0] : '0;
    reply.total = CNT_W'(held_count);
    return reply;
  endfunction

  // Key values are drawn from a narrow pool most of the time so that ties on
  // one, two or all three keys come up often; a quarter are full range.
  function automatic logic [31:0] pick_word32();
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_word16();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    e.sum       = pick_word32();
    e.interest  = pick_word16();
    e.late_fees = pick_word32();
    e.tag       = 16'($urandom);
    return e;
  endfunction

  // Offers one request transaction, after a random gap, and records the
  // expected reply at the edge where it is accepted.
  task automatic send_request(req_e kind, entry_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.new_sum       <= item.sum;
    req_if.new_interest  <= item.interest;
    req_if.new_late_fees <= item.late_fees;
    req_if.new_tag       <= item.tag;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_replies.push_back(apply_request(kind, item));
    if (kind == REQ_INSERT) inserts_sent++;
    else removes_sent++;
    if (expected_replies[$].status == ST_FULL) full_drops++;
    if (expected_replies[$].status == ST_EMPTY) empty_removes++;
    if (held_count > peak_count) peak_count = held_count;
  endtask

  task automatic send_insert(logic [31:0] s, logic [15:0] i, logic [31:0] f, logic [15:0] t);
    entry_t e;
    e = '{sum: s, interest: i, late_fees: f, tag: t};
    send_request(REQ_INSERT, e);
  endtask

  // The new_* fields of a remove are ignored, so they carry random noise.
  task automatic send_remove();
    send_request(REQ_REMOVE, random_entry());
  endtask

  task automatic test_remove_on_empty();
    send_remove();
  endtask

  // Extremes of every key and ties on one, two and all three keys; the
  // second all-ones entry must land ahead of the first one.
  task automatic test_key_ordering();
    send_insert('0, '0, '0, 16'h0001);
    send_insert('1, '1, '1, 16'hFFFF);
    send_insert('1, '1, '1, 16'h5A5A);
    send_insert('1, 16'hFFFE, '1, 16'h1234);
    send_insert('1, '1, 32'hFFFF_FFFE, 16'h4321);
    send_insert('0, '0, '0, 16'h0002);
  endtask

  // Fill the queue, offer a top-ranked entry that must be dropped, then
  // take a few entries off the tail and insert one more random entry.
  task automatic test_fill_to_full();
    while (held_count < DEPTH) send_request(REQ_INSERT, random_entry());
    send_insert('1, '1, '1, 16'hBEEF);
    repeat (3) send_remove();
    send_request(REQ_INSERT, random_entry());
  endtask

  // Blocks of forty requests alternate between mostly inserts and mostly
  // removes, so the queue swings between full and empty again and again;
  // every fifth block is an even mix.
  task automatic test_random_traffic(int unsigned items, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned insert_pct;
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    insert_pct      = 80;
    for (int unsigned n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        if ((n / 40) % 5 == 4) insert_pct = 50;
        else insert_pct = ((n / 40) % 2 == 0) ? 80 : 20;
      end
      if ($urandom_range(99) < insert_pct) send_request(REQ_INSERT, random_entry());
      else send_remove();
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the response register fills and the block stops accepting.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    hold_pending    = 1'b1;
    repeat (40) begin
      if ($urandom_range(99) < 60) send_request(REQ_INSERT, random_entry());
      else send_remove();
    end
  endtask

  task automatic wait_for_drain();
    int unsigned waited;
    waited = 0;
    req_if.valid <= 1'b0;
    sink_stall_pct = 0;
    while (expected_replies.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_replies.size() != 0) begin
      $display("%0d expected replies never arrived", expected_replies.size());
      failures += expected_replies.size();
    end
  endtask

  // Receiver side: random stalls, or a long hold-off counted here in cycles.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        for (int unsigned c = 1; c < LONG_HOLD; c++) begin
          @(posedge clk_i);
          rsp_if.ready <= 1'b0;
        end
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Every accepted response transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_replies
    queue_reply_t want;
    bit           bad;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] reply with nothing expected: sum=%h total=%0d status=%0d",
                   $realtime, rsp_if.head_sum, rsp_if.entry_total, rsp_if.status);
      end else begin
        want = expected_replies.pop_front();
        bad  = (rsp_if.head_sum != want.head.sum) ||
               (rsp_if.head_interest != want.head.interest) ||
               (rsp_if.head_late_fees != want.head.late_fees) ||
               (rsp_if.head_tag != want.head.tag) ||
               (rsp_if.entry_total != want.total) ||
               (rsp_if.status != want.status);
        if (bad) begin
          failures++;
          if (failures <= 10) begin
            $display("[%0t] expected sum=%h int=%h fees=%h tag=%h total=%0d status=%0d",
                     $realtime, want.head.sum, want.head.interest, want.head.late_fees,
                     want.head.tag, want.total, want.status);
            $display("          actual   sum=%h int=%h fees=%h tag=%h total=%0d status=%0d",
                     rsp_if.head_sum, rsp_if.head_interest, rsp_if.head_late_fees,
                     rsp_if.head_tag, rsp_if.entry_total, rsp_if.status);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Run did not finish in time");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_INSERT;
    req_if.new_sum       <= '0;
    req_if.new_interest  <= '0;
    req_if.new_late_fees <= '0;
    req_if.new_tag       <= '0;
    held_count      = 0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    hold_pending    = 1'b0;
    failures        = 0;
    inserts_sent    = 0;
    removes_sent    = 0;
    full_drops      = 0;
    empty_removes   = 0;
    peak_count      = 0;
    replies_seen    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_remove_on_empty();
    test_key_ordering();
    test_fill_to_full();
    test_random_traffic(280, 0, 0);
    test_random_traffic(280, 81, 0);
    test_random_traffic(280, 0, 81);
    test_random_traffic(280, 17, 17);
    test_backpressure();
    wait_for_drain();

    $display("Sent %0d inserts and %0d removes, %0d replies checked, peak depth %0d of %0d.",
             inserts_sent, removes_sent, replies_seen, peak_count, DEPTH);
    $display("Inserts dropped on a full queue: %0d; removes ignored on an empty queue: %0d.",
             full_drops, empty_removes);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", failures);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_req_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_core.sv
hw/rtl/spq_checker.sv
bench/testbench.sv
